// ===== src/sfd_pkg.sv =====
package sfd_pkg;

    localparam int FRAME_LENGTH = 16;
    localparam int POS_W        = 4;

    localparam logic [7:0] SYNC_FIRST  = 8'd240;
    localparam logic [7:0] SYNC_SECOND = 8'd15;

    localparam logic [POS_W-1:0] POS_FIRST_DATA = 4'd2;
    localparam logic [POS_W-1:0] POS_MOIST_HI   = 4'd3;
    localparam logic [POS_W-1:0] POS_MOIST_LO   = 4'd4;
    localparam logic [POS_W-1:0] POS_TEMP_INT   = 4'd6;
    localparam logic [POS_W-1:0] POS_TEMP_FRAC  = 4'd7;
    localparam logic [POS_W-1:0] POS_HUM_INT    = 4'd9;
    localparam logic [POS_W-1:0] POS_HUM_FRAC   = 4'd10;
    localparam logic [POS_W-1:0] POS_UV         = 4'd12;
    localparam logic [POS_W-1:0] POS_CHECK      = 4'd14;

    localparam int FIELD_COUNT = 5;
    localparam int FLD_TEMP_INT  = 0;
    localparam int FLD_TEMP_FRAC = 1;
    localparam int FLD_HUM_INT   = 2;
    localparam int FLD_HUM_FRAC  = 3;
    localparam int FLD_UV        = 4;

    typedef struct packed {
        logic [15:0] soil_moisture;
        logic [11:0] temperature_tenths;
        logic [11:0] humidity_tenths;
        logic [7:0]  uv_level;
    } result_t;

    function automatic logic [11:0] tenths(input logic [7:0] whole, input logic [7:0] frac);
        logic [11:0] x8;
        logic [11:0] x2;
        x8 = {1'b0, whole, 3'b000};
        x2 = {3'b000, whole, 1'b0};
        return x8 + x2 + {4'b0000, frac};
    endfunction

endpackage

// ===== src/sensor_frame_decoder.sv =====
// channel | signals                         | direction
// --------+---------------------------------+----------
// input   | in_valid, in_stall, rx_byte     | in
// result  | out_valid, out_stall, soil_moisture, temperature_tenths,
//         | humidity_tenths, uv_level       | out
//
// one received word is taken every cycle while in_stall is low; the result of a
// good frame is registered into the output register as its last word is accepted
// reset clears the hunt state, the checksum state and the valid flags of both result slots
// a result waits in the output register; a second one lands in a skid register,
// and in_stall is raised only while the skid register is full
module sensor_frame_decoder #(
    parameter int FRAME_LENGTH = sfd_pkg::FRAME_LENGTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] soil_moisture,
    output logic [11:0] temperature_tenths,
    output logic [11:0] humidity_tenths,
    output logic [7:0]  uv_level
);

    typedef enum logic [1:0] {
        HUNT       = 2'd0,
        SEEN_FIRST = 2'd1,
        IN_FRAME   = 2'd2
    } phase_t;

    localparam logic [sfd_pkg::POS_W-1:0] LAST_POS = sfd_pkg::POS_W'(FRAME_LENGTH - 1);

    phase_t                      phase_reg, phase_next;
    logic [sfd_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [7:0]                  sum_reg, sum_next;
    logic [15:0]                 moist_reg, moist_next;
    logic [7:0]                  field_reg [sfd_pkg::FIELD_COUNT];
    logic [7:0]                  field_next [sfd_pkg::FIELD_COUNT];
    logic                        good_reg, good_next;

    logic                        out_valid_reg, out_valid_next;
    sfd_pkg::result_t            out_data_reg, out_data_next;
    logic                        skid_valid_reg, skid_valid_next;
    sfd_pkg::result_t            skid_data_reg, skid_data_next;

    logic                        accept;
    logic                        taken;
    logic                        emit;
    sfd_pkg::result_t            result;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign taken    = out_valid_reg && !out_stall;

    // frame tracking
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        moist_next = moist_reg;
        good_next  = good_reg;
        field_next = field_reg;
        emit       = 1'b0;
        if (accept)
        begin
            case (phase_reg)
                SEEN_FIRST:
                begin
                    if (rx_byte == sfd_pkg::SYNC_SECOND)
                    begin
                        phase_next = IN_FRAME;
                        pos_next   = sfd_pkg::POS_FIRST_DATA;
                        sum_next   = 8'd0;
                        good_next  = 1'b0;
                    end
                    else if (rx_byte != sfd_pkg::SYNC_FIRST)
                    begin
                        phase_next = HUNT;
                    end
                end
                IN_FRAME:
                begin
                    case (pos_reg)
                        sfd_pkg::POS_MOIST_HI:
                        begin
                            moist_next = {rx_byte, 8'd0};
                            sum_next   = sum_reg + rx_byte;
                        end
                        sfd_pkg::POS_MOIST_LO:
                        begin
                            moist_next = {moist_reg[15:8], rx_byte};
                            sum_next   = sum_reg + rx_byte;
                        end
                        sfd_pkg::POS_TEMP_INT:
                        begin
                            field_next[sfd_pkg::FLD_TEMP_INT] = rx_byte;
                            sum_next = sum_reg + rx_byte;
                        end
                        sfd_pkg::POS_TEMP_FRAC:
                        begin
                            field_next[sfd_pkg::FLD_TEMP_FRAC] = rx_byte;
                            sum_next = sum_reg + rx_byte;
                        end
                        sfd_pkg::POS_HUM_INT:
                        begin
                            field_next[sfd_pkg::FLD_HUM_INT] = rx_byte;
                            sum_next = sum_reg + rx_byte;
                        end
                        sfd_pkg::POS_HUM_FRAC:
                        begin
                            field_next[sfd_pkg::FLD_HUM_FRAC] = rx_byte;
                            sum_next = sum_reg + rx_byte;
                        end
                        sfd_pkg::POS_UV:
                        begin
                            field_next[sfd_pkg::FLD_UV] = rx_byte;
                            sum_next = sum_reg + rx_byte;
                        end
                        sfd_pkg::POS_CHECK:
                        begin
                            good_next = (rx_byte == sum_reg);
                        end
                        default:
                        begin
                        end
                    endcase
                    if (pos_reg >= LAST_POS)
                    begin
                        phase_next = HUNT;
                        pos_next   = '0;
                        emit       = good_next;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_next = (rx_byte == sfd_pkg::SYNC_FIRST) ? SEEN_FIRST : HUNT;
                end
            endcase
        end
    end

    // decoded values, taken from the state after this word
    always_comb
    begin
        result.soil_moisture      = moist_next;
        result.temperature_tenths = sfd_pkg::tenths(field_next[sfd_pkg::FLD_TEMP_INT],
                                                     field_next[sfd_pkg::FLD_TEMP_FRAC]);
        result.humidity_tenths    = sfd_pkg::tenths(field_next[sfd_pkg::FLD_HUM_INT],
                                                    field_next[sfd_pkg::FLD_HUM_FRAC]);
        result.uv_level           = field_next[sfd_pkg::FLD_UV];
    end

    // output register and skid register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || taken)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (emit)
            begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (emit)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= HUNT;
            pos_reg        <= '0;
            sum_reg        <= '0;
            moist_reg      <= '0;
            good_reg       <= 1'b0;
            field_reg      <= '{default: '0};
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            sum_reg        <= sum_next;
            moist_reg      <= moist_next;
            good_reg       <= good_next;
            field_reg      <= field_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid          = out_valid_reg;
    assign soil_moisture      = out_data_reg.soil_moisture;
    assign temperature_tenths = out_data_reg.temperature_tenths;
    assign humidity_tenths    = out_data_reg.humidity_tenths;
    assign uv_level           = out_data_reg.uv_level;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid register filled without a stalled result");

    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == IN_FRAME |-> (pos_reg >= sfd_pkg::POS_FIRST_DATA && pos_reg <= LAST_POS))
        else $error("frame position out of range");

    a_result_from_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(accept && phase_reg == IN_FRAME && pos_reg == LAST_POS))
        else $error("result raised away from a frame end");
`endif

endmodule
